FILE: hw/rtl/ssel_pkg.sv
// Shared types and constants for the scanline sprite selector.
package ssel_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned PosW     = ByteW + 1;
  localparam int unsigned YOffset  = 16;
  localparam int unsigned ShortH   = 8;
  localparam int unsigned TallH    = 16;
  localparam int unsigned XSlack   = 9;
  localparam int unsigned HeldW    = 4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_QUERY
  } state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic scan;
    logic query;
  } cmd_t;

  // One stored object entry.
  typedef struct packed {
    logic [ByteW-1:0] flags;
    logic [ByteW-1:0] tile;
    logic [ByteW-1:0] x;
    logic [ByteW-1:0] y;
  } entry_t;

endpackage

FILE: hw/rtl/scanline_sprite_selector_unit.sv
// Top level of the scanline sprite selector: controller plus datapath.
//
// Usage: drive an item on the input ports and raise start; it is transferred
// at a rising edge where start is high and busy is low. mode_i selects a scan
// item (0: offer one object entry for the current line, first_entry_i empties
// the buffer first) or a query item (1: return and remove the first held
// entry whose x is at most pixel_pos_i + 9; later entries move down).
// Exactly one result per item appears on the result ports for one cycle,
// marked by done_o in the cycle after the execution cycle. busy is high for
// the one execution cycle; an item can be transferred in the same cycle its
// predecessor's result is shown, so a new item is never taken while the last
// one executes. The item passes through the capture register and then the
// execution cycle, in which the match search, compaction and store update run.
// The receiver cannot stall: results are never held back.
// tall_sprites_i is written at any edge with tall_sprites_we_i high and
// selects 8x16 sprites; write it only while no item is in flight.
// Reset (rst_ni low, asynchronous) empties the buffer and clears the
// configuration bit; entry slots are not cleared and are never read unwritten.
module scanline_sprite_selector_unit #(
  parameter int unsigned MAX_SPRITES = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  output logic                        done_o,
  input  logic                        tall_sprites_we_i,
  input  logic                        tall_sprites_i,
  input  logic                        mode_i,
  input  logic                        first_entry_i,
  input  logic [ssel_pkg::ByteW-1:0]  line_i,
  input  logic [ssel_pkg::ByteW-1:0]  entry_y_i,
  input  logic [ssel_pkg::ByteW-1:0]  entry_x_i,
  input  logic [ssel_pkg::ByteW-1:0]  entry_tile_i,
  input  logic [ssel_pkg::ByteW-1:0]  entry_flags_i,
  input  logic [ssel_pkg::ByteW-1:0]  pixel_pos_i,
  output logic                        accepted_o,
  output logic                        hit_o,
  output logic [ssel_pkg::ByteW-1:0]  sprite_y_o,
  output logic [ssel_pkg::ByteW-1:0]  sprite_x_o,
  output logic [ssel_pkg::ByteW-1:0]  sprite_tile_o,
  output logic [ssel_pkg::ByteW-1:0]  sprite_flags_o,
  output logic [ssel_pkg::HeldW-1:0]  held_count_o
);

  ssel_pkg::cmd_t cmd;

  ssel_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .mode_i (mode_i),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  ssel_dp #(
    .MAX_SPRITES (MAX_SPRITES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .tall_we_i      (tall_sprites_we_i),
    .tall_i         (tall_sprites_i),
    .first_entry_i  (first_entry_i),
    .line_i         (line_i),
    .entry_y_i      (entry_y_i),
    .entry_x_i      (entry_x_i),
    .entry_tile_i   (entry_tile_i),
    .entry_flags_i  (entry_flags_i),
    .pixel_pos_i    (pixel_pos_i),
    .accepted_o     (accepted_o),
    .hit_o          (hit_o),
    .sprite_y_o     (sprite_y_o),
    .sprite_x_o     (sprite_x_o),
    .sprite_tile_o  (sprite_tile_o),
    .sprite_flags_o (sprite_flags_o),
    .held_count_o   (held_count_o)
  );

endmodule

FILE: hw/rtl/ssel_ctrl.sv
// Controller: sequences capture, execution and the result strobe.
module ssel_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  logic          mode_i,
  output logic          busy,
  output logic          done_o,
  output ssel_pkg::cmd_t cmd_o
);

  ssel_pkg::state_e state_q, state_d;
  logic             done_q, done_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ssel_pkg::ST_IDLE: begin
        if (start) begin
          state_d = mode_i ? ssel_pkg::ST_QUERY : ssel_pkg::ST_SCAN;
        end
      end
      ssel_pkg::ST_SCAN:  state_d = ssel_pkg::ST_IDLE;
      ssel_pkg::ST_QUERY: state_d = ssel_pkg::ST_IDLE;
      default:            state_d = ssel_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.load  = 1'b0;
    cmd_o.scan  = 1'b0;
    cmd_o.query = 1'b0;
    busy        = 1'b1;
    unique case (state_q)
      ssel_pkg::ST_IDLE: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      ssel_pkg::ST_SCAN:  cmd_o.scan  = 1'b1;
      ssel_pkg::ST_QUERY: cmd_o.query = 1'b1;
      default:            busy        = 1'b1;
    endcase
  end

  assign done_d = cmd_o.scan | cmd_o.query;
  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ssel_pkg::ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  a_load_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> busy) else $error("transfer accepted but controller stayed idle");

  a_exec_then_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> (done_o && !busy)) else $error("execution did not end in one result");

endmodule

FILE: hw/rtl/ssel_dp.sv
// Datapath: sprite store, visibility test, match search and compaction.
module ssel_dp #(
  parameter int unsigned MAX_SPRITES = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ssel_pkg::cmd_t              cmd_i,
  input  logic                        tall_we_i,
  input  logic                        tall_i,
  input  logic                        first_entry_i,
  input  logic [ssel_pkg::ByteW-1:0]  line_i,
  input  logic [ssel_pkg::ByteW-1:0]  entry_y_i,
  input  logic [ssel_pkg::ByteW-1:0]  entry_x_i,
  input  logic [ssel_pkg::ByteW-1:0]  entry_tile_i,
  input  logic [ssel_pkg::ByteW-1:0]  entry_flags_i,
  input  logic [ssel_pkg::ByteW-1:0]  pixel_pos_i,
  output logic                        accepted_o,
  output logic                        hit_o,
  output logic [ssel_pkg::ByteW-1:0]  sprite_y_o,
  output logic [ssel_pkg::ByteW-1:0]  sprite_x_o,
  output logic [ssel_pkg::ByteW-1:0]  sprite_tile_o,
  output logic [ssel_pkg::ByteW-1:0]  sprite_flags_o,
  output logic [ssel_pkg::HeldW-1:0]  held_count_o
);

  localparam int unsigned CW = $clog2(MAX_SPRITES + 1);
  localparam int unsigned IW = (MAX_SPRITES > 1) ? $clog2(MAX_SPRITES) : 1;

  // Captured item.
  logic                       first_q;
  logic [ssel_pkg::ByteW-1:0] line_q, pos_q;
  ssel_pkg::entry_t           item_q;

  logic                       tall_q;
  logic [CW-1:0]              count_q, count_d;
  ssel_pkg::entry_t           store_q [MAX_SPRITES];
  ssel_pkg::entry_t           store_d [MAX_SPRITES];

  logic                       accepted_q, accepted_d;
  logic                       hit_q, hit_d;
  ssel_pkg::entry_t           result_q, result_d;

  logic [CW-1:0]              base_cnt;
  logic [ssel_pkg::PosW-1:0]  line_off, y_top, y_end, limit;
  logic                       visible, take;
  logic [MAX_SPRITES-1:0]     match;
  logic                       found;
  logic [IW-1:0]              hit_idx;

  // Visibility: line+16 >= y and line+16 < y+height, all without wrap.
  always_comb begin
    base_cnt = first_q ? '0 : count_q;
    line_off = {1'b0, line_q} + ssel_pkg::PosW'(ssel_pkg::YOffset);
    y_top    = {1'b0, item_q.y};
    y_end    = y_top + (tall_q ? ssel_pkg::PosW'(ssel_pkg::TallH)
                               : ssel_pkg::PosW'(ssel_pkg::ShortH));
    visible  = (line_off >= y_top) && (line_off < y_end);
    take     = visible && (base_cnt < CW'(MAX_SPRITES));
  end

  // Match every held entry against pos+9, keep the lowest slot.
  always_comb begin
    limit   = {1'b0, pos_q} + ssel_pkg::PosW'(ssel_pkg::XSlack);
    found   = 1'b0;
    hit_idx = '0;
    for (int k = 0; k < MAX_SPRITES; k++) begin
      match[k] = (CW'(k) < count_q) && ({1'b0, store_q[k].x} <= limit);
    end
    for (int k = MAX_SPRITES - 1; k >= 0; k--) begin
      if (match[k]) begin
        found   = 1'b1;
        hit_idx = IW'(k);
      end
    end
  end

  always_comb begin
    count_d    = count_q;
    accepted_d = accepted_q;
    hit_d      = hit_q;
    result_d   = result_q;
    for (int k = 0; k < MAX_SPRITES; k++) begin
      store_d[k] = store_q[k];
    end
    if (cmd_i.scan) begin
      accepted_d = take;
      hit_d      = 1'b0;
      result_d   = '0;
      count_d    = base_cnt + CW'(take);
      for (int k = 0; k < MAX_SPRITES; k++) begin
        if (take && (base_cnt == CW'(k))) begin
          store_d[k] = item_q;
        end
      end
    end else if (cmd_i.query) begin
      accepted_d = 1'b0;
      hit_d      = found;
      result_d   = found ? store_q[hit_idx] : '0;
      if (found) begin
        count_d = count_q - CW'(1);
        // Close the gap: every slot from the hit on takes its successor.
        for (int k = 0; k < MAX_SPRITES - 1; k++) begin
          if (k >= int'(hit_idx)) begin
            store_d[k] = store_q[k+1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tall_q  <= 1'b0;
      count_q <= '0;
    end else begin
      if (tall_we_i) begin
        tall_q <= tall_i;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      first_q <= first_entry_i;
      line_q  <= line_i;
      pos_q   <= pixel_pos_i;
      item_q  <= '{flags: entry_flags_i, tile: entry_tile_i,
                   x: entry_x_i, y: entry_y_i};
    end
    for (int k = 0; k < MAX_SPRITES; k++) begin
      store_q[k] <= store_d[k];
    end
    accepted_q <= accepted_d;
    hit_q      <= hit_d;
    result_q   <= result_d;
  end

  assign accepted_o     = accepted_q;
  assign hit_o          = hit_q;
  assign sprite_y_o     = result_q.y;
  assign sprite_x_o     = result_q.x;
  assign sprite_tile_o  = result_q.tile;
  assign sprite_flags_o = result_q.flags;
  assign held_count_o   = ssel_pkg::HeldW'(count_q);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_SPRITES)) else $error("held count exceeds store depth");

  a_hit_removes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.query && found) |=> (count_q == $past(count_q) - CW'(1)))
    else $error("hit did not remove one entry");

  a_scan_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan |=> (!hit_q && result_q == '0))
    else $error("scan produced sprite data");

endmodule

FILE: tb/sv/scanline_sprite_selector_unit_tb.sv
// Self-checking testbench for the scanline sprite selector: scans, queries, both heights.
module scanline_sprite_selector_unit_tb;

  localparam int unsigned SLOTS = 10;

  typedef enum logic {
    ITEM_SCAN  = 1'b0,
    ITEM_QUERY = 1'b1
  } item_kind_e;

  typedef struct packed {
    logic                               accepted;
    logic                               hit;
    ssel_pkg::entry_t                   sprite;
    logic [ssel_pkg::HeldW-1:0]         held;
  } sprite_result_t;

  // Line buffer shadow: tracks held entries and queues the result each item must give.
  class oam_line_buffer;
    ssel_pkg::entry_t slots[SLOTS];
    int unsigned      held;
    bit               tall;
    sprite_result_t   due_results[$];
    int unsigned      mismatches;
    int unsigned      scans, kept, dropped_full, queries, hits;

    function void take_item(item_kind_e kind, logic first, logic [7:0] scan_line,
                            ssel_pkg::entry_t offered, logic [7:0] pos);
      sprite_result_t r;
      int unsigned    h, top, limit;
      bit             visible;
      r = '0;
      if (kind == ITEM_SCAN) begin
        scans++;
        if (first) held = 0;
        h = tall ? ssel_pkg::TallH : ssel_pkg::ShortH;
        top = scan_line + ssel_pkg::YOffset;
        visible = (top >= offered.y) && (top < offered.y + h);
        if (visible && held < SLOTS) begin
          slots[held] = offered;
          held++;
          r.accepted = 1'b1;
          kept++;
        end else if (visible) begin
          dropped_full++;
        end
      end else begin
        queries++;
        limit = pos + ssel_pkg::XSlack;
        for (int i = 0; i < held && !r.hit; i++) begin
          if (slots[i].x <= limit) begin
            r.hit = 1'b1;
            r.sprite = slots[i];
            // close the gap behind the removed entry
            for (int k = i; k + 1 < held; k++) slots[k] = slots[k+1];
            held--;
            hits++;
          end
        end
      end
      r.held = held[ssel_pkg::HeldW-1:0];
      due_results.insert(due_results.size(), r);
    endfunction

    function void report(string what, sprite_result_t want, sprite_result_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t %s: exp acc=%0b hit=%0b y=%0h x=%0h tile=%0h flags=%0h held=%0d",
                 $time, what, want.accepted, want.hit, want.sprite.y, want.sprite.x,
                 want.sprite.tile, want.sprite.flags, want.held);
        $display("    got acc=%0b hit=%0b y=%0h x=%0h tile=%0h flags=%0h held=%0d",
                 got.accepted, got.hit, got.sprite.y, got.sprite.x,
                 got.sprite.tile, got.sprite.flags, got.held);
      end
    endfunction

    function void compare_result(sprite_result_t got);
      sprite_result_t want;
      if (due_results.size() == 0) begin
        report("result with nothing outstanding", '0, got);
      end else begin
        want = due_results.pop_front();
        if (got.accepted !== want.accepted || got.hit !== want.hit ||
            got.sprite.y !== want.sprite.y || got.sprite.x !== want.sprite.x ||
            got.sprite.tile !== want.sprite.tile || got.sprite.flags !== want.sprite.flags ||
            got.held !== want.held)
          report("result mismatch", want, got);
      end
    endfunction
  endclass

  logic                        clk_i;
  logic                        rst_ni;
  logic                        start;
  logic                        busy;
  logic                        done_o;
  logic                        tall_sprites_we_i;
  logic                        tall_sprites_i;
  logic                        mode_i;
  logic                        first_entry_i;
  logic [ssel_pkg::ByteW-1:0]  line_i;
  logic [ssel_pkg::ByteW-1:0]  entry_y_i;
  logic [ssel_pkg::ByteW-1:0]  entry_x_i;
  logic [ssel_pkg::ByteW-1:0]  entry_tile_i;
  logic [ssel_pkg::ByteW-1:0]  entry_flags_i;
  logic [ssel_pkg::ByteW-1:0]  pixel_pos_i;
  logic                        accepted_o;
  logic                        hit_o;
  logic [ssel_pkg::ByteW-1:0]  sprite_y_o;
  logic [ssel_pkg::ByteW-1:0]  sprite_x_o;
  logic [ssel_pkg::ByteW-1:0]  sprite_tile_o;
  logic [ssel_pkg::ByteW-1:0]  sprite_flags_o;
  logic [ssel_pkg::HeldW-1:0]  held_count_o;

  oam_line_buffer lb;
  int unsigned    items_sent;

  scanline_sprite_selector_unit #(
    .MAX_SPRITES(SLOTS)
  ) i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .done_o            (done_o),
    .tall_sprites_we_i (tall_sprites_we_i),
    .tall_sprites_i    (tall_sprites_i),
    .mode_i            (mode_i),
    .first_entry_i     (first_entry_i),
    .line_i            (line_i),
    .entry_y_i         (entry_y_i),
    .entry_x_i         (entry_x_i),
    .entry_tile_i      (entry_tile_i),
    .entry_flags_i     (entry_flags_i),
    .pixel_pos_i       (pixel_pos_i),
    .accepted_o        (accepted_o),
    .hit_o             (hit_o),
    .sprite_y_o        (sprite_y_o),
    .sprite_x_o        (sprite_x_o),
    .sprite_tile_o     (sprite_tile_o),
    .sprite_flags_o    (sprite_flags_o),
    .held_count_o      (held_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

  always @(posedge clk_i) begin : watch_results
    sprite_result_t got;
    if (rst_ni && done_o === 1'b1) begin
      got.accepted     = accepted_o;
      got.hit          = hit_o;
      got.sprite.y     = sprite_y_o;
      got.sprite.x     = sprite_x_o;
      got.sprite.tile  = sprite_tile_o;
      got.sprite.flags = sprite_flags_o;
      got.held         = held_count_o;
      lb.compare_result(got);
    end
  end

  // Present one item and hold it until the transfer; start stays high afterwards.
  task automatic send_item(item_kind_e kind, logic first, logic [7:0] scan_line,
                           ssel_pkg::entry_t offered, logic [7:0] pos);
    @(negedge clk_i);
    start         = 1'b1;
    mode_i        = kind;
    first_entry_i = first;
    line_i        = scan_line;
    entry_y_i     = offered.y;
    entry_x_i     = offered.x;
    entry_tile_i  = offered.tile;
    entry_flags_i = offered.flags;
    pixel_pos_i   = pos;
    do @(posedge clk_i); while (busy !== 1'b0);
    lb.take_item(kind, first, scan_line, offered, pos);
    items_sent++;
  endtask

  task automatic pause(int unsigned cycles);
    @(negedge clk_i);
    start = 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  task automatic maybe_pause(int unsigned pct);
    if ($urandom_range(99) < pct) pause($urandom_range(1, 4));
  endtask

  // Hold off until every outstanding result has come back.
  task automatic drain();
    @(negedge clk_i);
    start = 1'b0;
    while (lb.due_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_tall(bit value);
    drain();
    @(negedge clk_i);
    tall_sprites_we_i = 1'b1;
    tall_sprites_i    = value;
    @(posedge clk_i);
    lb.tall = value;
    @(negedge clk_i);
    tall_sprites_we_i = 1'b0;
  endtask

  function automatic ssel_pkg::entry_t mk_entry(int unsigned y, int unsigned x,
                                                int unsigned tile, int unsigned flags);
    ssel_pkg::entry_t e;
    e.y = y[7:0];
    e.x = x[7:0];
    e.tile = tile[7:0];
    e.flags = flags[7:0];
    return e;
  endfunction

  function automatic ssel_pkg::entry_t rand_entry();
    return mk_entry($urandom, $urandom, $urandom, $urandom);
  endfunction

  task automatic directed_items();
    write_tall(1'b0);
    send_item(ITEM_QUERY, 1'b0, 8'd0, rand_entry(), 8'd0);          // empty buffer
    send_item(ITEM_SCAN, 1'b1, 8'd0, mk_entry(16, 0, 0, 0), 8'd0);  // top edge of window
    send_item(ITEM_SCAN, 1'b0, 8'd0, mk_entry(9, 255, 255, 255), 8'hff); // bottom edge
    send_item(ITEM_SCAN, 1'b0, 8'd0, mk_entry(8, 3, 1, 2), 8'd0);
    send_item(ITEM_SCAN, 1'b0, 8'd0, mk_entry(17, 3, 1, 2), 8'd0);
    send_item(ITEM_SCAN, 1'b0, 8'd0, mk_entry(0, 3, 1, 2), 8'd0);
    send_item(ITEM_SCAN, 1'b0, 8'd246, mk_entry(255, 168, 170, 85), 8'd0); // no wrap
    for (int k = 0; k < 9; k++)  // fills the last seven slots; the first two are not visible
      send_item(ITEM_SCAN, 1'b0, 8'd153, mk_entry(160 + k, 20 + 8 * k, k, 255 - k), 8'd0);
    send_item(ITEM_QUERY, 1'b1, 8'd0, rand_entry(), 8'd0);          // flag ignored
    send_item(ITEM_QUERY, 1'b0, 8'd0, rand_entry(), 8'd0);          // no match
    send_item(ITEM_QUERY, 1'b0, 8'd0, rand_entry(), 8'd255);        // pos+9 past a byte
    send_item(ITEM_QUERY, 1'b0, 8'd0, rand_entry(), 8'd159);
    send_item(ITEM_SCAN, 1'b1, 8'd255, mk_entry(0, 0, 0, 0), 8'd0); // clear, not kept
    write_tall(1'b1);
    send_item(ITEM_SCAN, 1'b1, 8'd0, mk_entry(1, 9, 4, 4), 8'd0);
    send_item(ITEM_SCAN, 1'b0, 8'd0, mk_entry(0, 9, 4, 4), 8'd0);
    send_item(ITEM_SCAN, 1'b0, 8'd0, mk_entry(17, 9, 4, 4), 8'd0);
    send_item(ITEM_SCAN, 1'b0, 8'd255, mk_entry(255, 1, 4, 4), 8'd0);
  endtask

  // One scanline: an object scan led by the clear flag, then queries at non-decreasing positions, some at a random one.
  task automatic run_line(int unsigned pct);
    int unsigned      scan_line, n_scan, n_query, h, pos;
    int               y;
    logic             first;
    ssel_pkg::entry_t e;
    scan_line = ($urandom_range(9) == 0) ? $urandom_range(154, 255) : $urandom_range(0, 153);
    n_scan = ($urandom_range(5) == 0) ? $urandom_range(1, 40) : $urandom_range(8, 24);
    n_query = $urandom_range(0, 14);
    h = lb.tall ? ssel_pkg::TallH : ssel_pkg::ShortH;
    pos = $urandom_range(0, 20);
    for (int k = 0; k < n_scan; k++) begin
      y = scan_line + ssel_pkg::YOffset - $urandom_range(0, h - 1);
      if ($urandom_range(99) >= 55 || y > 255) y = $urandom_range(0, 255);
      e = mk_entry(y, ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 168),
                   $urandom, $urandom);
      first = (k == 0) ? 1'b1 : ($urandom_range(49) == 0);
      send_item(ITEM_SCAN, first, scan_line[7:0], e, 8'($urandom));
      maybe_pause(pct);
    end
    for (int k = 0; k < n_query; k++) begin
      send_item(ITEM_QUERY, 1'($urandom), scan_line[7:0], rand_entry(),
                ($urandom_range(9) == 0) ? 8'($urandom) : pos[7:0]);
      pos = pos + $urandom_range(0, 12);
      if (pos > 159) pos = 159;
      maybe_pause(pct);
    end
  endtask

  task automatic run_noise(int unsigned pct);
    repeat ($urandom_range(1, 4)) begin
      send_item(item_kind_e'($urandom_range(1)), 1'($urandom), 8'($urandom), rand_entry(),
                8'($urandom));
      maybe_pause(pct);
    end
  endtask

  initial begin
    int unsigned idle_plan[6];
    bit          tall_plan[6];
    int unsigned phase_end, pct;
    idle_plan = '{0, 70, 23, 0, 70, 23};
    tall_plan = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
    lb = new();
    items_sent = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    tall_sprites_we_i = 1'b0;
    tall_sprites_i = 1'b0;
    mode_i = ITEM_SCAN;
    first_entry_i = 1'b0;
    line_i = '0;
    entry_y_i = '0;
    entry_x_i = '0;
    entry_tile_i = '0;
    entry_flags_i = '0;
    pixel_pos_i = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    directed_items();
    for (int p = 0; p < 6; p++) begin
      write_tall(tall_plan[p]);
      phase_end = items_sent + 180;
      while (items_sent < phase_end) begin
        // leave some lines without gaps even in idle-heavy phases
        pct = ($urandom_range(4) == 0) ? 0 : idle_plan[p];
        if ($urandom_range(7) == 0) run_noise(pct);
        else run_line(pct);
      end
    end

    drain();
    repeat (4) @(posedge clk_i);
    $display("ran %0d items over 6 phases with 8x8 and 8x16 sprites, sender idling 0/23/70%%",
             items_sent);
    $display("scans %0d (kept %0d, dropped on full %0d), queries %0d (hits %0d)",
             lb.scans, lb.kept, lb.dropped_full, lb.queries, lb.hits);
    if (lb.mismatches == 0 && lb.due_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
